>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/mks_pkg.sv
// ---------------------------------------------------------------------------
// mks_pkg
// Shared types and constants for the k-th smallest / median selector.
// ---------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

    localparam int MKS_MAX_ELEMENTS = 64;
    localparam int SAMPLE_W         = 32;
    localparam int ORDER_W          = 6;
    localparam int STATUS_W         = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANK_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // word index of each register (paddr[2])
    localparam logic REG_SELECT_MODE = 1'b0;
    localparam logic REG_ORDER_INDEX = 1'b1;

    localparam logic MODE_KTH    = 1'b0;
    localparam logic MODE_MEDIAN = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } t_cell_ctl;

    // what a cell shows its neighbours
    typedef struct packed {
        logic                       gt;
        logic                       valid;
        logic signed [SAMPLE_W-1:0] val;
    } t_link;

endpackage

`default_nettype wire

>>> rtl/mks_cell.sv
// ---------------------------------------------------------------------------
// mks_cell
// One slot of the sorted chain: insert with shift-right, drain shift-left, clear empties.
// ---------------------------------------------------------------------------
`default_nettype none

module mks_cell
    import mks_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic signed [SAMPLE_W-1:0] i_x,
    input  wire t_link                 i_left,
    input  wire t_link                 i_right,
    output t_link                      o_link
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_val;
    logic                       n_valid;
    logic signed [SAMPLE_W-1:0] n_val;
    logic                       gt;

    // empty slot counts as +inf
    assign gt = !r_valid || (r_val > i_x);

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.insert) begin
            if (gt) begin
                n_val   = i_left.gt ? i_left.val : i_x;
                n_valid = r_valid | i_left.valid;
            end
        end else if (i_ctl.shift) begin
            n_val   = i_right.val;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link = '{gt: gt, valid: r_valid, val: r_val};

endmodule

`default_nettype wire

>>> rtl/median_kth_select_core.sv
// ---------------------------------------------------------------------------
// median_kth_select_core
// Order-statistic selector: sorted insertion chain with shift-out readout.
// ---------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[31:0] sample, tlast last
// m_axis    out  m_axis_tvalid/tready       tdata[31:0] result, tuser[1:0] status
// apb       in   psel/penable/pwrite/pready select_mode @0x0, order_index @0x4
//
// Samples are taken one per cycle while ready is high; each word inserts into
// the sorted chain unless full. A closing word shifts the chain towards cell 0
// until the rank read out (0 on error) is there, then its result is registered.
// Ready drops while the chain drains and while a finished result waits there.
// Reset is synchronous; the chain comes up empty, registers at their defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module median_kth_select_core
    import mks_pkg::*;
#(
    parameter int MAX_ELEMENTS = MKS_MAX_ELEMENTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // s_axis_tdata: [31:0] sample
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,
    input  wire         s_axis_tlast,
    // m_axis_tdata: [31:0] result
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,
    // m_axis_tuser: [1:0] status
    output logic [1:0]  m_axis_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int KW = (CW > ORDER_W) ? CW : ORDER_W;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    // configuration
    logic               r_mode;
    logic [ORDER_W-1:0] r_order;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MEDIAN;
            r_order <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SELECT_MODE: r_mode  <= pwdata[0];
                REG_ORDER_INDEX: r_order <= pwdata[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SELECT_MODE: prdata = 32'(r_mode);
            REG_ORDER_INDEX: prdata = 32'(r_order);
            default:         prdata = '0;
        endcase
    end

    // control
    logic [0:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [IW-1:0]       r_rank, n_rank;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_even, n_even;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_data, n_out_data;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic          accept, full, out_free;
    logic [CW-1:0] cnt_close, cnt_m1;
    logic          ovf_close;
    logic [SAMPLE_W:0] sum;
    t_cell_ctl     ctl;
    t_link         links [MAX_ELEMENTS];
    t_link         lefts [MAX_ELEMENTS];
    t_link         rights[MAX_ELEMENTS];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_count == CW'(MAX_ELEMENTS));
    assign out_free      = !r_out_valid || m_axis_tready;
    assign cnt_close     = full ? r_count : r_count + CW'(1);
    assign cnt_m1        = cnt_close - CW'(1);
    assign ovf_close     = r_ovf || full;
    assign sum           = {links[0].val[SAMPLE_W-1], links[0].val}
                         + {links[1].val[SAMPLE_W-1], links[1].val};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_rank       = r_rank;
        n_status     = r_status;
        n_even       = r_even;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        ctl          = '{insert: 1'b0, shift: 1'b0, clear: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ctl.insert = !full;
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (s_axis_tlast) begin
                        n_state = S_DRAIN;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_even  = 1'b0;
                        n_rank  = '0;
                        if (ovf_close) begin
                            n_status = ST_OVERFLOW;
                        end else if (r_mode == MODE_KTH) begin
                            if (KW'(r_order) >= KW'(cnt_close)) begin
                                n_status = ST_RANK_ERR;
                            end else begin
                                n_status = ST_OK;
                                n_rank   = IW'(r_order);
                            end
                        end else begin
                            n_status = ST_OK;
                            n_rank   = IW'(cnt_m1 >> 1);
                            n_even   = !cnt_close[0];
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (r_rank != '0) begin
                    ctl.shift = 1'b1;
                    n_rank    = r_rank - IW'(1);
                end else if (out_free) begin
                    ctl.clear    = 1'b1;
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    if (r_status != ST_OK) begin
                        n_out_data = '0;
                    end else if (r_even) begin
                        n_out_data = sum[SAMPLE_W:1];
                    end else begin
                        n_out_data = links[0].val;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rank      <= '0;
            r_status    <= ST_OK;
            r_even      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rank      <= n_rank;
            r_status    <= n_status;
            r_even      <= n_even;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // neighbour wiring; cell 0 sees a full, never-greater left edge
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            if (i == 0) begin
                lefts[i] = '{gt: 1'b0, valid: 1'b1, val: '0};
            end else begin
                lefts[i] = links[i-1];
            end
            if (i == MAX_ELEMENTS - 1) begin
                rights[i] = '{gt: 1'b1, valid: 1'b0, val: '0};
            end else begin
                rights[i] = links[i+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_chain
        mks_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_x     (signed'(s_axis_tdata)),
            .i_left  (lefts[g]),
            .i_right (rights[g]),
            .o_link  (links[g])
        );
    end

endmodule

`default_nettype wire

>>> rtl/mks_checker.sv
// ---------------------------------------------------------------------------
// mks_checker
// Port-level checks on the selector, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mks_checker
    import mks_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);

    logic close_acc;
    logic err_word;
    logic status_known;

    assign close_acc    = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign err_word     = m_axis_tvalid && (m_axis_tuser != ST_OK);
    assign status_known = (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_RANK_ERR)
                       || (m_axis_tuser == ST_OVERFLOW);

    // a result is held until taken
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // error words carry zero data
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, err_word, m_axis_tdata == '0)

    `ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, m_axis_tvalid, status_known)

    // closing word stalls the input while the chain drains
    `ASSERT_NEXT(a_close_stall, i_clk, i_rst_n, close_acc, !s_axis_tready)

    // a new result only comes out of a drain
    `ASSERT_IMPLY(a_result_src, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind median_kth_select_core mks_checker u_mks_checker (.*);

`default_nettype wire
